// File: rtl/thread_ready_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the thread ready priority queue
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef THREAD_READY_PRIORITY_QUEUE_MACROS_SVH
`define THREAD_READY_PRIORITY_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only while the block is out of reset.
`define TRPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every clock edge, reset included.
`define TRPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TRPQ_ASSERT(label, clk, rst_n, prop, msg)
`define TRPQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: rtl/trpq_pkg.sv
// ----------------------------------------------------------------------------
// Thread ready priority queue package
// Command and status codes, beat layout and sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package trpq_pkg;

    // Command codes carried in the input beat.
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_ERASE = 2'd2;

    // Status codes returned in the result beat.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_EMPTY   = 2'd2;
    localparam logic [1:0] STAT_NOMATCH = 2'd3;

    // Stamp widths; the stamp follows the priority in the sort key.
    localparam int SEC_W   = 32;
    localparam int USEC_W  = 20;
    localparam int STAMP_W = SEC_W + USEC_W;

    // Beat widths.
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 24;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH_RD,
        ST_PUSH_CHK,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_HEAD_RD,
        ST_HEAD_LD
    } trpq_state_t;

    // Flags from the shared compare unit.
    typedef struct packed {
        logic key_first; // new key sorts strictly ahead of the slot key
        logic id_match;  // thread id equals the slot's id
    } trpq_cmp_t;

endpackage

// File: rtl/trpq_store.sv
// ----------------------------------------------------------------------------
// Entry store
// Simple dual-port memory for queue slots: one write and one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trpq_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 68
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/trpq_cmp.sv
// ----------------------------------------------------------------------------
// Key compare unit
// Shared comparator: sort order of the new key against one slot, and id match.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trpq_cmp
    import trpq_pkg::*;
#(
    parameter int ID_BITS = 8,
    parameter int KEY_W   = 60
) (
    input  logic [KEY_W-1:0]   new_key,
    input  logic [KEY_W-1:0]   slot_key,
    input  logic [ID_BITS-1:0] new_id,
    input  logic [ID_BITS-1:0] slot_id,
    output trpq_cmp_t          result
);

    // The key is {priority, seconds, microseconds}, so one magnitude compare
    // gives the lexicographic order.
    always_comb begin
        result.key_first = (new_key < slot_key);
        result.id_match  = (new_id == slot_id);
    end

endmodule

// File: rtl/thread_ready_priority_queue.sv
// ----------------------------------------------------------------------------
// Thread ready priority queue
// Sorted queue of thread entries with push, pop of the head and erase by id.
// ----------------------------------------------------------------------------
// Usage: each beat on the s_ channel carries one command (push, pop, erase).
// The block answers every command with exactly one beat on the m_ channel:
// a status, the head entry after the command and the entry count.
// Entries sit sorted in a slot memory, head at slot 0. A small sequencer
// walks the occupied slots one at a time through a single key comparator,
// reading each slot and then acting on it: a push walks to its place and
// moves the later entries up, a pop or erase moves the later entries down.
// s_tready is high only while the sequencer is idle. It comes back in the
// same cycle as the result beat turns valid, so a command occupies the block
// until its result is loaded into the output register.
// The result sits in an output register, so the next command is accepted
// while the previous result waits. If the receiver stalls and a second result
// is ready, the sequencer holds it until the output register frees.
// Reset empties the queue; slot contents need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "thread_ready_priority_queue_macros.svh"

module thread_ready_priority_queue
    import trpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8,
    parameter int PRIO_BITS   = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // cmd[1:0], thread_id[9:2], priority_req[17:10], stamp_sec[49:18],
    // stamp_usec[69:50], zero pad [71:70]
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // status[1:0], head_valid[2], head_thread_id[10:3], head_priority[18:11],
    // entry_count[23:19]
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready
);

    localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int KEY_W   = PRIO_BITS + STAMP_W;
    localparam int ENTRY_W = ID_BITS + KEY_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    // Input beat fields.
    logic [1:0]         in_cmd;
    logic [7:0]         in_thread_id;
    logic [7:0]         in_priority_req;
    logic [SEC_W-1:0]   in_stamp_sec;
    logic [USEC_W-1:0]  in_stamp_usec;
    logic [ID_BITS+7:0]   in_id_ext;
    logic [PRIO_BITS+7:0] in_prio_ext;
    logic [ID_BITS-1:0]   in_id;
    logic [KEY_W-1:0]     in_key;

    assign in_cmd          = s_tdata[1:0];
    assign in_thread_id    = s_tdata[9:2];
    assign in_priority_req = s_tdata[17:10];
    assign in_stamp_sec    = s_tdata[49:18];
    assign in_stamp_usec   = s_tdata[69:50];

    // Only the low ID_BITS and PRIO_BITS are kept.
    assign in_id_ext   = {{ID_BITS{1'b0}}, in_thread_id};
    assign in_prio_ext = {{PRIO_BITS{1'b0}}, in_priority_req};
    assign in_id       = in_id_ext[ID_BITS-1:0];
    assign in_key      = {in_prio_ext[PRIO_BITS-1:0], in_stamp_sec, in_stamp_usec};

    // Sequencer and datapath registers.
    trpq_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [ENTRY_W-1:0] carry_reg, carry_next;
    logic               carrying_reg, carrying_next;
    logic [1:0]         status_reg, status_next;

    // Output register.
    logic       out_valid_reg, out_valid_next;
    logic [1:0] out_status_reg, out_status_next;
    logic       out_hv_reg, out_hv_next;
    logic [7:0] out_id_reg, out_id_next;
    logic [7:0] out_prio_reg, out_prio_next;
    logic [4:0] out_cnt_reg, out_cnt_next;

    // Slot memory controls.
    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;
    logic               mem_rd_en;
    logic [ADDR_W-1:0]  mem_rd_addr;
    logic [ENTRY_W-1:0] mem_rd_data;

    logic [CNT_W-1:0]   idx_plus1;
    logic               out_free;
    logic               out_load;
    logic               in_beat;
    trpq_cmp_t          cmp;

    logic [ID_BITS-1:0]   rd_id;
    logic [KEY_W-1:0]     rd_key;
    logic [ID_BITS+7:0]   head_id_ext;
    logic [PRIO_BITS+7:0] head_prio_ext;
    logic [CNT_W+4:0]     occ_ext;

    assign idx_plus1 = idx_reg + CNT_ONE;
    assign rd_id     = mem_rd_data[ENTRY_W-1:KEY_W];
    assign rd_key    = mem_rd_data[KEY_W-1:0];
    assign out_free  = !out_valid_reg || m_tready;
    assign out_load  = (state_reg == ST_HEAD_LD) && out_free;
    assign in_beat   = s_tvalid && s_tready;

    assign head_id_ext   = {8'd0, rd_id};
    assign head_prio_ext = {8'd0, rd_key[KEY_W-1:STAMP_W]};
    assign occ_ext       = {5'd0, occ_reg};

    // Slot memory.
    trpq_store #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Shared compare unit.
    trpq_cmp #(
        .ID_BITS (ID_BITS),
        .KEY_W   (KEY_W)
    ) u_cmp (
        .new_key  (key_reg),
        .slot_key (rd_key),
        .new_id   (id_reg),
        .slot_id  (rd_id),
        .result   (cmp)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    if (in_cmd == CMD_PUSH && occ_reg < DEPTH_CNT) begin
                        state_next = ST_PUSH_RD;
                    end else if (in_cmd == CMD_POP && occ_reg != '0) begin
                        state_next = ST_SHIFT_RD;
                    end else if (in_cmd == CMD_ERASE) begin
                        state_next = ST_FIND_RD;
                    end else begin
                        state_next = ST_HEAD_RD;
                    end
                end
            end
            ST_PUSH_RD: begin
                state_next = (idx_reg == occ_reg) ? ST_HEAD_RD : ST_PUSH_CHK;
            end
            ST_PUSH_CHK: begin
                state_next = ST_PUSH_RD;
            end
            ST_FIND_RD: begin
                state_next = (idx_reg == occ_reg) ? ST_HEAD_RD : ST_FIND_CHK;
            end
            ST_FIND_CHK: begin
                state_next = cmp.id_match ? ST_SHIFT_RD : ST_FIND_RD;
            end
            ST_SHIFT_RD: begin
                state_next = (idx_plus1 < occ_reg) ? ST_SHIFT_WR : ST_HEAD_RD;
            end
            ST_SHIFT_WR: begin
                state_next = ST_SHIFT_RD;
            end
            ST_HEAD_RD: begin
                state_next = ST_HEAD_LD;
            end
            ST_HEAD_LD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory controls for each state.
    always_comb begin
        idx_next      = idx_reg;
        occ_next      = occ_reg;
        id_next       = id_reg;
        key_next      = key_reg;
        carry_next    = carry_reg;
        carrying_next = carrying_reg;
        status_next   = status_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = idx_reg[ADDR_W-1:0];
        mem_wr_data   = carry_reg;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = idx_reg[ADDR_W-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    id_next       = in_id;
                    key_next      = in_key;
                    carry_next    = {in_id, in_key};
                    carrying_next = 1'b0;
                    idx_next      = '0;
                    status_next   = STAT_OK;
                    if (in_cmd == CMD_PUSH && occ_reg >= DEPTH_CNT) begin
                        status_next = STAT_FULL;
                    end else if (in_cmd == CMD_POP && occ_reg == '0) begin
                        status_next = STAT_EMPTY;
                    end else if (in_cmd == CMD_ERASE) begin
                        status_next = STAT_NOMATCH;
                    end
                end
            end
            ST_PUSH_RD: begin
                if (idx_reg == occ_reg) begin
                    // End of the walk: the carried entry goes in the free slot.
                    mem_wr_en = 1'b1;
                    occ_next  = occ_reg + CNT_ONE;
                end else begin
                    mem_rd_en = 1'b1;
                end
            end
            ST_PUSH_CHK: begin
                // From the insertion point on, each slot takes the carried
                // entry and its old entry is carried one place up.
                if (carrying_reg || cmp.key_first) begin
                    mem_wr_en     = 1'b1;
                    carry_next    = mem_rd_data;
                    carrying_next = 1'b1;
                end
                idx_next = idx_plus1;
            end
            ST_FIND_RD: begin
                if (idx_reg != occ_reg) begin
                    mem_rd_en = 1'b1;
                end
            end
            ST_FIND_CHK: begin
                if (cmp.id_match) begin
                    status_next = STAT_OK;
                end else begin
                    idx_next = idx_plus1;
                end
            end
            ST_SHIFT_RD: begin
                if (idx_plus1 < occ_reg) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_plus1[ADDR_W-1:0];
                end else begin
                    occ_next = occ_reg - CNT_ONE;
                end
            end
            ST_SHIFT_WR: begin
                // Move the next entry down over the removed one.
                mem_wr_en   = 1'b1;
                mem_wr_data = mem_rd_data;
                idx_next    = idx_plus1;
            end
            ST_HEAD_RD: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
            end
            ST_HEAD_LD: begin
            end
            default: begin
            end
        endcase
    end

    // Output register: loaded with the result, cleared when the beat is taken.
    always_comb begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_hv_next     = out_hv_reg;
        out_id_next     = out_id_reg;
        out_prio_next   = out_prio_reg;
        out_cnt_next    = out_cnt_reg;
        if (out_load) begin
            out_valid_next  = 1'b1;
            out_status_next = status_reg;
            out_hv_next     = (occ_reg != '0);
            out_id_next     = (occ_reg != '0) ? head_id_ext[7:0] : 8'd0;
            out_prio_next   = (occ_reg != '0) ? head_prio_ext[7:0] : 8'd0;
            out_cnt_next    = occ_ext[4:0];
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        id_reg         <= id_next;
        key_reg        <= key_next;
        carry_reg      <= carry_next;
        carrying_reg   <= carrying_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_hv_reg     <= out_hv_next;
        out_id_reg     <= out_id_next;
        out_prio_reg   <= out_prio_next;
        out_cnt_reg    <= out_cnt_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_cnt_reg, out_prio_reg, out_id_reg, out_hv_reg, out_status_reg};

    // Checks on the queue bookkeeping.
    `TRPQ_ASSERT(a_occ_bound, aclk, aresetn, occ_reg <= DEPTH_CNT, "occupancy above depth")
    `TRPQ_ASSERT(a_occ_step, aclk, aresetn,
        (occ_reg == $past(occ_reg)) || (occ_reg == $past(occ_reg) + CNT_ONE) ||
        (occ_reg + CNT_ONE == $past(occ_reg)),
        "occupancy moved by more than one")
    `TRPQ_ASSERT(a_wr_in_range, aclk, aresetn,
        mem_wr_en |-> (idx_reg <= occ_reg && occ_reg != '0 || idx_reg == '0),
        "slot write outside the occupied range")
    `TRPQ_ASSERT(a_full_status, aclk, aresetn,
        (out_load && status_reg == STAT_FULL) |-> (occ_reg == DEPTH_CNT),
        "full status with free slots")
    `TRPQ_ASSERT(a_empty_status, aclk, aresetn,
        (out_load && status_reg == STAT_EMPTY) |-> (occ_reg == '0),
        "empty status with entries held")
    `TRPQ_ASSERT(a_push_done, aclk, aresetn,
        (state_reg == ST_PUSH_RD && idx_reg == occ_reg) |=>
        (occ_reg == $past(occ_reg) + CNT_ONE),
        "push did not add an entry")

endmodule

// File: sim/thread_ready_priority_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thread ready priority queue checker
// Watches both streams of the queue, keeps its own sorted copy of the thread
// entries and compares every result beat, field by field, with the oldest
// reply that the copy predicts.
// ----------------------------------------------------------------------------

module thread_ready_priority_queue_checker
    import trpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    output int                   mismatch_count,
    output int                   replies_owed
);

    // Replies that may be owed at once; the block holds at most two.
    localparam int REPLY_SLOTS = 16;

    // Command beat, lowest field in the lowest bits.
    typedef struct packed {
        logic [1:0]        pad;
        logic [USEC_W-1:0] usec;
        logic [SEC_W-1:0]  sec;
        logic [7:0]        prio;
        logic [7:0]        id;
        logic [1:0]        cmd;
    } command_beat_t;

    // Reply beat, status in the lowest bits.
    typedef struct packed {
        logic [4:0] count;
        logic [7:0] head_prio;
        logic [7:0] head_id;
        logic       head_valid;
        logic [1:0] status;
    } queue_reply_t;

    // Priority on top, then seconds, then microseconds: a plain unsigned
    // compare of the concatenation gives the queue order.
    typedef logic [7+STAMP_W:0] sort_key_t;

    sort_key_t    entry_key [QUEUE_DEPTH];
    logic [7:0]   entry_id  [QUEUE_DEPTH];
    int           entries_held = 0;
    queue_reply_t reply_fifo [REPLY_SLOTS];
    logic [3:0]   reply_wr_ptr = '0;
    logic [3:0]   reply_rd_ptr = '0;
    int           reply_fill   = 0;
    int           bad_replies  = 0;

    // Drop the entry at pos and close the gap.
    function automatic void drop_entry(input int pos);
        int i;
        for (i = pos; i < entries_held - 1; i++) begin
            entry_key[i] = entry_key[i + 1];
            entry_id[i]  = entry_id[i + 1];
        end
        entries_held--;
    endfunction

    // Apply one command to the sorted copy and return the reply it earns.
    function automatic queue_reply_t run_command(input command_beat_t c);
        queue_reply_t r;
        sort_key_t    k;
        int           pos;
        int           i;
        r        = '0;
        r.status = STAT_OK;
        k        = {c.prio, c.sec, c.usec};
        case (c.cmd)
            CMD_PUSH: begin
                if (entries_held >= QUEUE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    // A new entry goes behind every entry whose key is not greater.
                    pos = entries_held;
                    for (i = 0; i < entries_held; i++) begin
                        if (pos == entries_held && k < entry_key[i]) pos = i;
                    end
                    for (i = entries_held; i > pos; i--) begin
                        entry_key[i] = entry_key[i - 1];
                        entry_id[i]  = entry_id[i - 1];
                    end
                    entry_key[pos] = k;
                    entry_id[pos]  = c.id;
                    entries_held++;
                end
            end
            CMD_POP: begin
                if (entries_held == 0) r.status = STAT_EMPTY;
                else drop_entry(0);
            end
            CMD_ERASE: begin
                // Only the first matching id in queue order is removed.
                pos = -1;
                for (i = 0; i < entries_held; i++) begin
                    if (pos < 0 && entry_id[i] == c.id) pos = i;
                end
                if (pos < 0) r.status = STAT_NOMATCH;
                else drop_entry(pos);
            end
            default: ;
        endcase
        if (entries_held > 0) begin
            r.head_valid = 1'b1;
            r.head_id    = entry_id[0];
            r.head_prio  = entry_key[0][7+STAMP_W -: 8];
        end
        r.count = 5'(entries_held);
        return r;
    endfunction

    // Commands are predicted as they are taken; replies are checked in order.
    always @(posedge aclk) begin
        queue_reply_t want;
        queue_reply_t got;
        if (!aresetn) begin
            entries_held = 0;
            reply_wr_ptr = '0;
            reply_rd_ptr = '0;
            reply_fill   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (reply_fill == REPLY_SLOTS) begin
                    bad_replies++;
                    if (bad_replies <= 10) begin
                        $display("%0t: command beat taken with %0d replies still owed",
                                 $realtime, reply_fill);
                    end
                end else begin
                    reply_fifo[reply_wr_ptr] = run_command(command_beat_t'(s_tdata));
                    reply_wr_ptr = reply_wr_ptr + 4'd1;
                    reply_fill++;
                end
            end
            if (m_tvalid && m_tready) begin
                got = queue_reply_t'(m_tdata);
                if (reply_fill == 0) begin
                    bad_replies++;
                    if (bad_replies <= 10) begin
                        $display("%0t: reply beat with nothing owed: %s%0d %s%0d %s%0d",
                                 $realtime, "status=", got.status,
                                 "valid=", got.head_valid, "id=", got.head_id);
                        $display("%0t:   prio=%0d count=%0d",
                                 $realtime, got.head_prio, got.count);
                    end
                end else begin
                    want = reply_fifo[reply_rd_ptr];
                    reply_rd_ptr = reply_rd_ptr + 4'd1;
                    reply_fill--;
                    if (got.status != want.status || got.head_valid != want.head_valid ||
                        got.head_id != want.head_id || got.head_prio != want.head_prio ||
                        got.count != want.count) begin
                        bad_replies++;
                        if (bad_replies <= 10) begin
                            $display("%0t: reply mismatch: want status=%0d valid=%0d %s%0d %s%0d %s%0d",
                                     $realtime, want.status, want.head_valid,
                                     "id=", want.head_id, "prio=", want.head_prio,
                                     "count=", want.count);
                            $display("%0t:                  got status=%0d valid=%0d %s%0d %s%0d %s%0d",
                                     $realtime, got.status, got.head_valid,
                                     "id=", got.head_id, "prio=", got.head_prio,
                                     "count=", got.count);
                        end
                    end
                end
            end
        end
        mismatch_count <= bad_replies;
        replies_owed   <= reply_fill;
    end

endmodule

// File: sim/thread_ready_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thread ready priority queue testbench
// Drives directed and random push, pop, erase and unused-code beats into the queue with
// random gaps on both streams and one long stall of the result stream, and
// gives the verdict from the checker's count of bad replies and of replies still owed.
// ----------------------------------------------------------------------------

module thread_ready_priority_queue_tb;

    import trpq_pkg::*;

    localparam int         QUEUE_DEPTH  = 16;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_CMDS  = 850;
    localparam int         CALM_CMDS    = 120;
    localparam int         HOLD_AFTER   = 300;
    localparam int         HOLD_CYCLES  = 400;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    int   mismatch_count;
    int   replies_owed;
    int   cmds_taken = 0;
    logic calm       = 1'b0;
    logic hold_rx    = 1'b0;

    always #5 aclk = ~aclk;

    thread_ready_priority_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .ID_BITS    (8),
        .PRIO_BITS  (8)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    thread_ready_priority_queue_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .mismatch_count(mismatch_count),
        .replies_owed  (replies_owed)
    );

    // Offer one command beat, maybe after a short gap, and wait until taken.
    task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] id,
                            input logic [7:0] prio, input logic [SEC_W-1:0] sec,
                            input logic [USEC_W-1:0] usec);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, usec, sec, prio, id, cmd};
        do @(posedge aclk); while (!s_tready);
        cmds_taken++;
    endtask

    // One random command; ids mostly come from a narrow range and key fields
    // often do, so that erases hit and equal keys turn up.
    task automatic send_random(input logic [1:0] cmd);
        logic [7:0]        id;
        logic [7:0]        prio;
        logic [SEC_W-1:0]  sec;
        logic [USEC_W-1:0] usec;
        id   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        prio = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        case ($urandom_range(0, 3))
            0:       sec = $urandom_range(0, 2);
            1:       sec = 32'hFFFF_FFFF - $urandom_range(0, 2);
            default: sec = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0, 1:    usec = 20'($urandom_range(0, 2));
            2:       usec = 20'($urandom);
            default: usec = 20'($urandom_range(0, 999999));
        endcase
        send_cmd(cmd, id, prio, sec, usec);
    endtask

    // Result stream: short random stalls, a long hold when asked, none at the end.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_rx) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                m_tready   <= 1'b0;
                stall_left = $urandom_range(0, 8);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Hold the result stream long enough for the queue to back up its input.
    initial begin
        while (cmds_taken < HOLD_AFTER) @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    // Stimulus and verdict.
    initial begin
        int         k;
        int         done_cmds;
        int         push_pct;
        int         r;
        logic [1:0] cmd;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Commands on an empty queue.
        send_cmd(CMD_POP, 8'h00, 8'h00, 32'h0, 20'h0);
        send_cmd(CMD_ERASE, 8'h00, 8'h00, 32'h0, 20'h0);
        send_cmd(CMD_UNUSED, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 20'hFFFFF);

        // Extreme keys, then ties broken by seconds and microseconds, and a
        // fully equal key that must queue behind the first.
        send_cmd(CMD_PUSH, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 20'hFFFFF);
        send_cmd(CMD_PUSH, 8'h00, 8'h00, 32'h0, 20'h0);
        send_cmd(CMD_PUSH, 8'h01, 8'h05, 32'd10, 20'd7);
        send_cmd(CMD_PUSH, 8'h02, 8'h05, 32'd10, 20'd7);
        send_cmd(CMD_PUSH, 8'h03, 8'h05, 32'd10, 20'd6);
        send_cmd(CMD_PUSH, 8'h04, 8'h05, 32'd9, 20'd999999);

        // Fill up, with one id repeated, then push into the full queue.
        for (k = 0; k < 10; k++) begin
            send_cmd(CMD_PUSH, (k == 4) ? 8'h01 : 8'(16 + k), 8'(k * 28), 32'(k),
                     20'(k * 100000));
        end
        send_cmd(CMD_PUSH, 8'h55, 8'h00, 32'h0, 20'h0);

        // Erase a repeated id, erase a missing one, pop, and an unused code.
        send_cmd(CMD_ERASE, 8'h01, 8'h00, 32'h0, 20'h0);
        send_cmd(CMD_ERASE, 8'h77, 8'h00, 32'h0, 20'h0);
        send_cmd(CMD_POP, 8'h00, 8'h00, 32'h0, 20'h0);
        send_cmd(CMD_UNUSED, 8'hA5, 8'h5A, 32'h1234_5678, 20'h9ABCD);

        // Random phases that lean towards filling or draining the queue.
        done_cmds = 0;
        push_pct  = 50;
        while (done_cmds < RANDOM_CMDS) begin
            if (done_cmds % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 80;
                    1:       push_pct = 50;
                    default: push_pct = 20;
                endcase
            end
            if (done_cmds >= RANDOM_CMDS - CALM_CMDS) calm <= 1'b1;
            if ($urandom_range(0, 29) == 0) begin
                send_random(CMD_UNUSED);
            end else begin
                r = $urandom_range(0, 99);
                if (r < push_pct) cmd = CMD_PUSH;
                else if (r < push_pct + (100 - push_pct) / 2) cmd = CMD_POP;
                else cmd = CMD_ERASE;
                send_random(cmd);
                done_cmds++;
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then watch for stray beats.
        @(posedge aclk);
        while (replies_owed != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0 && replies_owed == 0) begin
            $display("thread_ready_priority_queue_tb: done, clean");
        end else begin
            $display("thread_ready_priority_queue_tb: done, errors");
        end
        $finish;
    end

    // Overall time limit, several times the slowest correct run.
    initial begin
        #5_000_000;
        $display("thread_ready_priority_queue_tb: done, errors");
        $finish;
    end

endmodule
